// ===== sv/chnt_pkg.sv =====
// Shared types and constants for the coalesced hash name table.
package chnt_pkg;

    localparam int SLOTS      = 64;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int NEXT_W     = SLOT_W + 1;
    localparam int NAME_BYTES = 32;
    localparam int NAME_W     = $clog2(NAME_BYTES);
    localparam int LEN_W      = NAME_W + 1;
    localparam int HASH_W     = 32;
    localparam int HANDLER_W  = 16;
    localparam int STATUS_W   = 3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_TOO_LONG  = 3'd5
    } t_status;

    typedef struct packed {
        logic                 op;
        logic                 too_long;
        logic [NAME_W-1:0]    len;
        logic [HASH_W-1:0]    hash;
        logic [HANDLER_W-1:0] handler;
    } t_cmd;

    typedef struct packed {
        logic [NAME_W-1:0]    len;
        logic [HASH_W-1:0]    hash;
        logic [NEXT_W-1:0]    next;
        logic [HANDLER_W-1:0] handler;
    } t_meta;

    typedef enum logic [3:0] {
        S_IDLE,
        S_META_RD,
        S_META_CHK,
        S_NAME_RD,
        S_NAME_CHK,
        S_PROBE,
        S_STORE_META,
        S_COPY,
        S_LINK,
        S_RESULT
    } t_state;

endpackage

// ===== sv/chnt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module chnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/chnt_front.sv =====
// Front end: collects name bytes, runs the hash and issues one command per name.
module chnt_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_operation,
    input  logic [7:0]                    i_key_byte,
    input  logic                          i_last_byte,
    input  logic [chnt_pkg::HANDLER_W-1:0] i_handler_value,
    input  logic                          i_q_full,
    output logic                          o_push,
    output chnt_pkg::t_cmd                o_cmd,
    input  logic                          i_done,
    input  logic [chnt_pkg::NAME_W-1:0]   i_rd_idx,
    output logic [7:0]                    o_rd_byte
);

    logic [7:0]                    r_buf [chnt_pkg::NAME_BYTES];
    logic [chnt_pkg::LEN_W-1:0]    r_len;
    logic [chnt_pkg::LEN_W-1:0]    n_len;
    logic [chnt_pkg::HASH_W-1:0]   r_hash;
    logic [chnt_pkg::HASH_W-1:0]   n_hash;
    logic                          r_busy;
    logic                          acc;
    logic                          room;

    // The buffer is held for the back end until it reports the command done.
    assign o_in_ready = !r_busy && !i_q_full;
    assign acc        = i_in_valid && o_in_ready;
    assign room       = (r_len != chnt_pkg::LEN_W'(chnt_pkg::NAME_BYTES));
    assign n_hash     = r_hash ^ ((r_hash << 5) + (r_hash >> 2)
                        + {{(chnt_pkg::HASH_W-8){1'b0}}, i_key_byte});
    assign n_len      = room ? r_len + 1'b1 : r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_hash <= '0;
            r_busy <= 1'b0;
        end else begin
            if (i_done) begin
                r_busy <= 1'b0;
            end
            if (acc) begin
                if (i_last_byte) begin
                    r_len  <= '0;
                    r_hash <= '0;
                    r_busy <= 1'b1;
                end else begin
                    r_len  <= n_len;
                    r_hash <= n_hash;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && room) begin
            r_buf[r_len[chnt_pkg::NAME_W-1:0]] <= i_key_byte;
        end
    end

    assign o_push         = acc && i_last_byte;
    assign o_cmd.op       = i_operation;
    assign o_cmd.too_long = (n_len == chnt_pkg::LEN_W'(chnt_pkg::NAME_BYTES));
    assign o_cmd.len      = n_len[chnt_pkg::NAME_W-1:0];
    assign o_cmd.hash     = n_hash;
    assign o_cmd.handler  = i_handler_value;
    assign o_rd_byte      = r_buf[i_rd_idx];

endmodule

// ===== sv/chnt_queue.sv =====
// Two-entry command queue between the front end and the back end.
module chnt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  chnt_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_avail,
    output chnt_pkg::t_cmd o_cmd
);

    chnt_pkg::t_cmd r_ent [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_cmd   = r_ent[r_rp];

endmodule

// ===== sv/chnt_back.sv =====
// Back end: walks chains, probes for free slots, stores names and returns results.
module chnt_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_avail,
    input  chnt_pkg::t_cmd                 i_cmd,
    output logic                           o_pop,
    output logic                           o_done,
    output logic [chnt_pkg::NAME_W-1:0]    o_rd_idx,
    input  logic [7:0]                     i_rd_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [chnt_pkg::STATUS_W-1:0]  o_status,
    output logic [chnt_pkg::SLOT_W-1:0]    o_slot_index,
    output logic [chnt_pkg::HANDLER_W-1:0] o_found_handler
);

    localparam int NADDR_W = chnt_pkg::SLOT_W + chnt_pkg::NAME_W;
    localparam int META_W  = $bits(chnt_pkg::t_meta);

    chnt_pkg::t_state r_state, n_state;
    chnt_pkg::t_cmd   r_cmd, n_cmd;
    chnt_pkg::t_meta  r_tail, n_tail;
    chnt_pkg::t_meta  meta_q;
    chnt_pkg::t_meta  meta_wd;

    logic [chnt_pkg::SLOTS-1:0]     r_valid, n_valid;
    logic [chnt_pkg::SLOT_W:0]      r_used, n_used;
    logic [chnt_pkg::SLOT_W-1:0]    r_cur, n_cur;
    logic [chnt_pkg::SLOT_W-1:0]    r_dst, n_dst;
    logic [chnt_pkg::SLOT_W-1:0]    r_steps, n_steps;
    logic [chnt_pkg::SLOT_W-1:0]    r_k, n_k;
    logic [chnt_pkg::NAME_W-1:0]    r_idx, n_idx;
    logic                           r_link, n_link;
    chnt_pkg::t_status              r_res_st, n_res_st;
    logic [chnt_pkg::SLOT_W-1:0]    r_res_slot, n_res_slot;
    logic [chnt_pkg::HANDLER_W-1:0] r_res_hd, n_res_hd;
    logic                           r_ov, n_ov;
    logic [chnt_pkg::STATUS_W-1:0]  r_o_st, n_o_st;
    logic [chnt_pkg::SLOT_W-1:0]    r_o_slot, n_o_slot;
    logic [chnt_pkg::HANDLER_W-1:0] r_o_hd, n_o_hd;

    logic [chnt_pkg::SLOT_W-1:0] home;
    logic [chnt_pkg::SLOT_W-1:0] probe;
    logic                        cand;
    logic                        chain_end;
    logic                        byte_eq;
    logic                        last_idx;
    logic                        out_free;
    logic                        meta_we;
    logic [chnt_pkg::SLOT_W-1:0] meta_wa;
    logic [META_W-1:0]           meta_rd;
    logic                        name_we;
    logic [7:0]                  name_q;

    assign meta_q    = chnt_pkg::t_meta'(meta_rd);
    assign home      = r_cmd.hash[chnt_pkg::SLOT_W-1:0];
    assign probe     = home + r_k;
    assign cand      = (meta_q.len == r_cmd.len)
                       && (r_cmd.op == chnt_pkg::OP_INSERT || meta_q.hash == r_cmd.hash);
    // The walk ends at the end-of-chain mark or after one visit per slot. In the
    // check state the link of the current slot is the one just read.
    assign chain_end = ((r_state == chnt_pkg::S_META_CHK) ? meta_q.next[chnt_pkg::SLOT_W]
                                                           : r_tail.next[chnt_pkg::SLOT_W])
                       || (r_steps == '1);
    assign byte_eq   = (name_q == i_rd_byte);
    assign last_idx  = (r_idx == r_cmd.len - 1'b1);
    assign out_free  = !r_ov || i_out_ready;

    chnt_ram #(.WIDTH(META_W), .DEPTH(chnt_pkg::SLOTS)) u_meta (
        .i_clk  (i_clk),
        .i_we   (meta_we),
        .i_waddr(meta_wa),
        .i_wdata(META_W'(meta_wd)),
        .i_raddr(r_cur),
        .o_rdata(meta_rd)
    );

    chnt_ram #(.WIDTH(8), .DEPTH(chnt_pkg::SLOTS * chnt_pkg::NAME_BYTES)) u_name (
        .i_clk  (i_clk),
        .i_we   (name_we),
        .i_waddr(NADDR_W'({r_dst, r_idx})),
        .i_wdata(i_rd_byte),
        .i_raddr(NADDR_W'({r_cur, r_idx})),
        .o_rdata(name_q)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chnt_pkg::S_IDLE: begin
                if (i_avail) begin
                    if (i_cmd.too_long) begin
                        n_state = chnt_pkg::S_RESULT;
                    end else if (i_cmd.op == chnt_pkg::OP_INSERT) begin
                        if (r_used[chnt_pkg::SLOT_W]) begin
                            n_state = chnt_pkg::S_RESULT;
                        end else if (!r_valid[i_cmd.hash[chnt_pkg::SLOT_W-1:0]]) begin
                            n_state = chnt_pkg::S_STORE_META;
                        end else begin
                            n_state = chnt_pkg::S_META_RD;
                        end
                    end else if (!r_valid[i_cmd.hash[chnt_pkg::SLOT_W-1:0]]) begin
                        n_state = chnt_pkg::S_RESULT;
                    end else begin
                        n_state = chnt_pkg::S_META_RD;
                    end
                end
            end
            chnt_pkg::S_META_RD:  n_state = chnt_pkg::S_META_CHK;
            chnt_pkg::S_META_CHK: n_state = cand ? chnt_pkg::S_NAME_RD : chnt_pkg::S_META_CHK;
            chnt_pkg::S_NAME_RD:  n_state = chnt_pkg::S_NAME_CHK;
            chnt_pkg::S_NAME_CHK: begin
                if (byte_eq && last_idx) begin
                    n_state = chnt_pkg::S_RESULT;
                end else if (byte_eq) begin
                    n_state = chnt_pkg::S_NAME_RD;
                end else begin
                    n_state = chnt_pkg::S_META_CHK;
                end
            end
            chnt_pkg::S_PROBE: begin
                if (!r_valid[probe]) begin
                    n_state = chnt_pkg::S_STORE_META;
                end else if (r_k == '1) begin
                    n_state = chnt_pkg::S_RESULT;
                end
            end
            chnt_pkg::S_STORE_META: n_state = chnt_pkg::S_COPY;
            chnt_pkg::S_COPY: begin
                if (last_idx) begin
                    n_state = r_link ? chnt_pkg::S_LINK : chnt_pkg::S_RESULT;
                end
            end
            chnt_pkg::S_LINK:   n_state = chnt_pkg::S_RESULT;
            chnt_pkg::S_RESULT: n_state = out_free ? chnt_pkg::S_IDLE : chnt_pkg::S_RESULT;
            default:            n_state = chnt_pkg::S_IDLE;
        endcase
        // A rejected candidate or mismatched byte steps on, or ends the chain walk.
        if ((r_state == chnt_pkg::S_META_CHK && !cand)
            || (r_state == chnt_pkg::S_NAME_CHK && !byte_eq)) begin
            if (chain_end) begin
                n_state = (r_cmd.op == chnt_pkg::OP_INSERT) ? chnt_pkg::S_PROBE
                                                            : chnt_pkg::S_RESULT;
            end else begin
                n_state = chnt_pkg::S_META_RD;
            end
        end
    end

    // Datapath and outputs.
    always_comb begin
        n_cmd      = r_cmd;
        n_tail     = r_tail;
        n_valid    = r_valid;
        n_used     = r_used;
        n_cur      = r_cur;
        n_dst      = r_dst;
        n_steps    = r_steps;
        n_k        = r_k;
        n_idx      = r_idx;
        n_link     = r_link;
        n_res_st   = r_res_st;
        n_res_slot = r_res_slot;
        n_res_hd   = r_res_hd;
        n_ov       = r_ov && !i_out_ready;
        n_o_st     = r_o_st;
        n_o_slot   = r_o_slot;
        n_o_hd     = r_o_hd;
        o_pop      = 1'b0;
        o_done     = 1'b0;
        meta_we    = 1'b0;
        meta_wa    = r_dst;
        meta_wd    = r_tail;
        name_we    = 1'b0;
        unique case (r_state)
            chnt_pkg::S_IDLE: begin
                if (i_avail) begin
                    o_pop      = 1'b1;
                    n_cmd      = i_cmd;
                    n_cur      = i_cmd.hash[chnt_pkg::SLOT_W-1:0];
                    n_dst      = i_cmd.hash[chnt_pkg::SLOT_W-1:0];
                    n_steps    = '0;
                    n_link     = 1'b0;
                    n_res_slot = '0;
                    n_res_hd   = '0;
                    n_res_st   = chnt_pkg::ST_NOT_FOUND;
                    if (i_cmd.too_long) begin
                        n_res_st = chnt_pkg::ST_TOO_LONG;
                    end else if (i_cmd.op == chnt_pkg::OP_INSERT && r_used[chnt_pkg::SLOT_W]) begin
                        n_res_st = chnt_pkg::ST_FULL;
                    end
                end
            end
            chnt_pkg::S_META_RD: begin
            end
            chnt_pkg::S_META_CHK: begin
                n_tail = meta_q;
                n_idx  = '0;
            end
            chnt_pkg::S_NAME_RD: begin
            end
            chnt_pkg::S_NAME_CHK: begin
                if (byte_eq && last_idx) begin
                    n_res_slot = r_cur;
                    if (r_cmd.op == chnt_pkg::OP_INSERT) begin
                        n_res_st = chnt_pkg::ST_DUPLICATE;
                    end else begin
                        n_res_st = chnt_pkg::ST_FOUND;
                        n_res_hd = r_tail.handler;
                    end
                end else if (byte_eq) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            chnt_pkg::S_PROBE: begin
                n_k = r_k + 1'b1;
                if (!r_valid[probe]) begin
                    n_dst  = probe;
                    n_link = 1'b1;
                end else if (r_k == '1) begin
                    n_res_st = chnt_pkg::ST_FULL;
                end
            end
            chnt_pkg::S_STORE_META: begin
                meta_we          = 1'b1;
                meta_wa          = r_dst;
                meta_wd.len      = r_cmd.len;
                meta_wd.hash     = r_cmd.hash;
                meta_wd.next     = chnt_pkg::NEXT_W'(chnt_pkg::SLOTS);
                meta_wd.handler  = r_cmd.handler;
                n_valid[r_dst]   = 1'b1;
                n_used           = r_used + 1'b1;
                n_idx            = '0;
                n_res_st         = chnt_pkg::ST_INSERTED;
                n_res_slot       = r_dst;
            end
            chnt_pkg::S_COPY: begin
                name_we = 1'b1;
                n_idx   = r_idx + 1'b1;
            end
            chnt_pkg::S_LINK: begin
                meta_we      = 1'b1;
                meta_wa      = r_cur;
                meta_wd.next = {1'b0, r_dst};
            end
            chnt_pkg::S_RESULT: begin
                if (out_free) begin
                    o_done   = 1'b1;
                    n_ov     = 1'b1;
                    n_o_st   = r_res_st;
                    n_o_slot = r_res_slot;
                    n_o_hd   = r_res_hd;
                end
            end
            default: begin
            end
        endcase
        if ((r_state == chnt_pkg::S_META_CHK && !cand)
            || (r_state == chnt_pkg::S_NAME_CHK && !byte_eq)) begin
            if (r_state == chnt_pkg::S_META_CHK) begin
                n_tail = meta_q;
            end
            n_cur   = (r_state == chnt_pkg::S_META_CHK) ? meta_q.next[chnt_pkg::SLOT_W-1:0]
                                                        : r_tail.next[chnt_pkg::SLOT_W-1:0];
            n_steps = r_steps + 1'b1;
            n_k     = chnt_pkg::SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chnt_pkg::S_IDLE;
            r_valid <= '0;
            r_used  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_used  <= n_used;
            r_ov    <= n_ov;
        end
    end

    // The chain tail stays in r_cur through the probe so that it can be linked.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_tail     <= n_tail;
        r_dst      <= n_dst;
        r_steps    <= n_steps;
        r_k        <= n_k;
        r_idx      <= n_idx;
        r_link     <= n_link;
        r_res_st   <= n_res_st;
        r_res_slot <= n_res_slot;
        r_res_hd   <= n_res_hd;
        r_o_st     <= n_o_st;
        r_o_slot   <= n_o_slot;
        r_o_hd     <= n_o_hd;
        if (!(n_state == chnt_pkg::S_PROBE && r_state != chnt_pkg::S_PROBE)) begin
            r_cur <= n_cur;
        end
    end

    assign o_rd_idx        = r_idx;
    assign o_out_valid     = r_ov;
    assign o_status        = r_o_st;
    assign o_slot_index    = r_o_slot;
    assign o_found_handler = r_o_hd;

endmodule

// ===== sv/coalesced_hash_name_table.sv =====
// Top level of the coalesced hash name table.
//
// A name enters one byte per transaction; the front end takes a byte every
// cycle while it collects a name. When the last byte is taken, the name is
// handed to the back end and the front end holds off new bytes until that
// command finishes. The back end reads one slot record per chain step
// through the metadata RAM, with a read state and a check state, and
// compares the name one byte at a time through the name RAM in the same
// way. It probes for a free slot one slot a cycle and copies a new name
// one byte a cycle. The valid bits reset at once, so no clearing pass is
// needed.
module coalesced_hash_name_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_operation,
    input  logic [7:0]                     i_key_byte,
    input  logic                           i_last_byte,
    input  logic [chnt_pkg::HANDLER_W-1:0] i_handler_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [chnt_pkg::STATUS_W-1:0]  o_status,
    output logic [chnt_pkg::SLOT_W-1:0]    o_slot_index,
    output logic [chnt_pkg::HANDLER_W-1:0] o_found_handler
);

    chnt_pkg::t_cmd              push_cmd;
    chnt_pkg::t_cmd              head_cmd;
    logic                        push;
    logic                        pop;
    logic                        q_full;
    logic                        q_avail;
    logic                        done;
    logic [chnt_pkg::NAME_W-1:0] rd_idx;
    logic [7:0]                  rd_byte;

    chnt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_key_byte     (i_key_byte),
        .i_last_byte    (i_last_byte),
        .i_handler_value(i_handler_value),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_cmd          (push_cmd),
        .i_done         (done),
        .i_rd_idx       (rd_idx),
        .o_rd_byte      (rd_byte)
    );

    chnt_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .o_full (q_full),
        .i_pop  (pop),
        .o_avail(q_avail),
        .o_cmd  (head_cmd)
    );

    chnt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_avail        (q_avail),
        .i_cmd          (head_cmd),
        .o_pop          (pop),
        .o_done         (done),
        .o_rd_idx       (rd_idx),
        .i_rd_byte      (rd_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_slot_index   (o_slot_index),
        .o_found_handler(o_found_handler)
    );

endmodule
